FILE: rtl/core/tmpm_pkg.sv
`default_nettype none

package tmpm_pkg;

   // Q1.16 fixed point for internal levels
   localparam int FRAC_BITS  = 16;
   localparam int ONE_Q      = 1 << FRAC_BITS;
   localparam int HALF_Q     = 1 << (FRAC_BITS - 1);
   localparam int LEVEL_W    = FRAC_BITS + 1;
   localparam int Q12_ONE    = 4096;

   // blend: m = num + floor((num*511 + 32512) / 65025)
   localparam int BLEND_DEN   = 65025;
   localparam int BLEND_EXTRA = 511;
   localparam int BLEND_BIAS  = 32512;
   localparam int RECIP_65025 = 66051;   // floor(2^32 / 65025)

   // neutral remap divider
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = 8;
   localparam int QUOT_W     = DIV_BITS * DIV_STAGES;

   // accept edge to the edge at which the result is sampled
   localparam int PIPE_LATENCY = 18;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [2:0] REG_BRIGHTNESS  = 3'd0;
   localparam logic [2:0] REG_CONTRAST    = 3'd1;
   localparam logic [2:0] REG_NEUTRAL     = 3'd2;
   localparam logic [2:0] REG_INVERT      = 3'd3;
   localparam logic [2:0] REG_CUTOFF_LOW  = 3'd4;
   localparam logic [2:0] REG_CUTOFF_HIGH = 3'd5;
   localparam logic [2:0] REG_CUTOFF_MODE = 3'd6;
   localparam logic [2:0] REG_ALPHA_MODE  = 3'd7;

   localparam logic [1:0] CUT_NONE        = 2'd0;
   localparam logic [1:0] CUT_TRANSPARENT = 2'd1;
   localparam logic [1:0] CUT_OPAQUE      = 2'd2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic [7:0] mask_value;
      logic [7:0] out_alpha;
   } mask_type;

   typedef struct packed {
      logic signed [13:0] brightness;
      logic [15:0]        contrast;
      logic [12:0]        neutral_point;
      logic               invert_enable;
      logic [7:0]         cutoff_low;
      logic [7:0]         cutoff_high;
      logic [1:0]         cutoff_mode;
      logic               alpha_mode;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      brightness:    14'sd0,
      contrast:      16'd4096,
      neutral_point: 13'd2048,
      invert_enable: 1'b0,
      cutoff_low:    8'd0,
      cutoff_high:   8'd255,
      cutoff_mode:   CUT_NONE,
      alpha_mode:    1'b0
   };

   typedef struct packed {
      logic               valid;
      logic [7:0]         alpha;
      logic [LEVEL_W-1:0] level;
   } level_type;

   typedef struct packed {
      logic               valid;
      logic [7:0]         alpha;
      logic [LEVEL_W-1:0] value;
   } remap_type;

endpackage

`default_nettype wire

FILE: rtl/core/tmpm_csr.sv
`default_nettype none

module tmpm_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [tmpm_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [tmpm_pkg::DATA_W-1:0]   pwdata,
   output logic      [tmpm_pkg::DATA_W-1:0]   prdata,
   output logic                               pready,
   output tmpm_pkg::cfg_type                  cfg
);

   localparam int ADDR_HI = tmpm_pkg::ADDR_W - 1;

   tmpm_pkg::cfg_type cfg_ff;
   tmpm_pkg::cfg_type cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index  = paddr[ADDR_HI:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            tmpm_pkg::REG_BRIGHTNESS:  cfg_in.brightness    = $signed(pwdata[13:0]);
            tmpm_pkg::REG_CONTRAST:    cfg_in.contrast      = pwdata[15:0];
            tmpm_pkg::REG_NEUTRAL:     cfg_in.neutral_point = pwdata[12:0];
            tmpm_pkg::REG_INVERT:      cfg_in.invert_enable = pwdata[0];
            tmpm_pkg::REG_CUTOFF_LOW:  cfg_in.cutoff_low    = pwdata[7:0];
            tmpm_pkg::REG_CUTOFF_HIGH: cfg_in.cutoff_high   = pwdata[7:0];
            tmpm_pkg::REG_CUTOFF_MODE: cfg_in.cutoff_mode   = pwdata[1:0];
            tmpm_pkg::REG_ALPHA_MODE:  cfg_in.alpha_mode    = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= tmpm_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         tmpm_pkg::REG_BRIGHTNESS:  prdata = {18'd0, cfg_ff.brightness};
         tmpm_pkg::REG_CONTRAST:    prdata = {16'd0, cfg_ff.contrast};
         tmpm_pkg::REG_NEUTRAL:     prdata = {19'd0, cfg_ff.neutral_point};
         tmpm_pkg::REG_INVERT:      prdata = {31'd0, cfg_ff.invert_enable};
         tmpm_pkg::REG_CUTOFF_LOW:  prdata = {24'd0, cfg_ff.cutoff_low};
         tmpm_pkg::REG_CUTOFF_HIGH: prdata = {24'd0, cfg_ff.cutoff_high};
         tmpm_pkg::REG_CUTOFF_MODE: prdata = {30'd0, cfg_ff.cutoff_mode};
         tmpm_pkg::REG_ALPHA_MODE:  prdata = {31'd0, cfg_ff.alpha_mode};
         default:                   prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/tmpm_level.sv
`default_nettype none

module tmpm_level (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire tmpm_pkg::pixel_type  pixel,
   input  wire tmpm_pkg::cfg_type    cfg,
   output tmpm_pkg::level_type       lvl_out
);

   localparam int LW = tmpm_pkg::LEVEL_W;

   // stage 1: weighted gray
   logic        v1_ff;
   logic [7:0]  gray1_ff;
   logic [7:0]  a1_ff;
   logic [12:0] gray_sum;

   // stage 2: blend numerator
   logic        v2_ff;
   logic [15:0] num2_ff;
   logic [7:0]  a2_ff;
   logic [16:0] num_in;

   // stage 3: reciprocal estimate
   logic        v3_ff;
   logic [15:0] num3_ff;
   logic [24:0] y3_ff;
   logic [8:0]  qe3_ff;
   logic [7:0]  a3_ff;
   logic [24:0] y_in;
   logic [41:0] qprod;

   // stage 4: corrected blend level
   logic          v4_ff;
   logic [LW-1:0] m4_ff;
   logic [7:0]    a4_ff;
   logic [24:0]   qmul;
   logic [24:0]   rem;
   logic          corr;

   // stage 5: brightness and recentering
   logic               v5_ff;
   logic signed [19:0] d5_ff;
   logic [7:0]         a5_ff;
   logic signed [19:0] m_ext;
   logic signed [19:0] b_ext;

   // stage 6: contrast product
   logic               v6_ff;
   logic signed [35:0] p6_ff;
   logic [7:0]         a6_ff;
   logic signed [36:0] prod;

   // stage 7: clamp and invert
   logic               v7_ff;
   logic [LW-1:0]      m7_ff;
   logic [7:0]         a7_ff;
   logic signed [24:0] t;
   logic [LW-1:0]      clamped;
   logic [LW-1:0]      m7_in;

   assign gray_sum = 13'(pixel.red) * 13'd11 + {1'b0, pixel.green, 4'b0000}
                   + 13'(pixel.blue) * 13'd5;

   assign num_in = 17'(gray1_ff) * 17'(a1_ff) + 17'd255 * 17'(8'd255 - a1_ff);

   assign y_in  = {num2_ff, 9'b0} - 25'(num2_ff) + 25'(tmpm_pkg::BLEND_BIAS);
   assign qprod = 42'(y_in) * 42'(tmpm_pkg::RECIP_65025);

   assign qmul = 25'(qe3_ff) * 25'(tmpm_pkg::BLEND_DEN);
   assign rem  = y3_ff - qmul;
   assign corr = (rem >= 25'(tmpm_pkg::BLEND_DEN));

   assign m_ext = $signed({3'b000, m4_ff});
   assign b_ext = $signed({{2{cfg.brightness[13]}}, cfg.brightness, 4'b0000});

   assign prod = d5_ff * $signed({1'b0, cfg.contrast}) + 37'sd2048;

   always_comb begin
      t = $signed({p6_ff[35], p6_ff[35:12]}) + 25'sd32768;
      if (t[24]) begin
         clamped = '0;
      end else if (t > 25'(tmpm_pkg::ONE_Q)) begin
         clamped = LW'(tmpm_pkg::ONE_Q);
      end else begin
         clamped = t[LW-1:0];
      end
      m7_in = cfg.invert_enable ? LW'(tmpm_pkg::ONE_Q) - clamped : clamped;
   end

   always_ff @(posedge clock) begin
      gray1_ff <= gray_sum[12:5];
      a1_ff    <= pixel.alpha;
      num2_ff  <= num_in[15:0];
      a2_ff    <= a1_ff;
      num3_ff  <= num2_ff;
      y3_ff    <= y_in;
      qe3_ff   <= qprod[40:32];
      a3_ff    <= a2_ff;
      m4_ff    <= LW'(num3_ff) + LW'(qe3_ff) + LW'(corr);
      a4_ff    <= a3_ff;
      d5_ff    <= m_ext - b_ext - 20'sd32768;
      a5_ff    <= a4_ff;
      p6_ff    <= prod[35:0];
      a6_ff    <= a5_ff;
      m7_ff    <= m7_in;
      a7_ff    <= a6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   assign lvl_out.valid = v7_ff;
   assign lvl_out.alpha = a7_ff;
   assign lvl_out.level = m7_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tmpm_remap.sv
`default_nettype none

module tmpm_remap (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tmpm_pkg::level_type  lvl_in,
   input  wire tmpm_pkg::cfg_type    cfg,
   output tmpm_pkg::remap_type       rmp_out
);

   localparam int LW     = tmpm_pkg::LEVEL_W;
   localparam int QW     = tmpm_pkg::QUOT_W;
   localparam int NSTG   = tmpm_pkg::DIV_STAGES;
   localparam int NUM_W  = 29;
   localparam int DEN_W  = 14;

   typedef struct packed {
      logic             valid;
      logic [7:0]       alpha;
      logic             upper;
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem;
      logic [QW-1:0]    nlow;
      logic [QW-1:0]    quot;
   } div_type;

   div_type stage_ff [NSTG+1];
   div_type stage_in [NSTG+1];

   logic [12:0]      n_sat;
   logic [12:0]      d_w;
   logic             lower_seg;
   logic [NUM_W-1:0] num_lo;
   logic [NUM_W-1:0] num_hi;
   logic [NUM_W-1:0] num_sel;

   // pick the segment and set up the divide
   always_comb begin
      n_sat = (cfg.neutral_point > 13'(tmpm_pkg::Q12_ONE)) ?
              13'(tmpm_pkg::Q12_ONE) : cfg.neutral_point;
      d_w   = 13'(tmpm_pkg::Q12_ONE) - n_sat;
      lower_seg = (n_sat == 13'(tmpm_pkg::Q12_ONE)) ||
                  ((n_sat != 13'd0) && (lvl_in.level <= {n_sat, 4'b0000}));
      num_lo  = {lvl_in.level, 12'b0} + NUM_W'(n_sat);
      num_hi  = {lvl_in.level, 12'b0} - {n_sat, 16'b0} + NUM_W'(d_w);
      num_sel = lower_seg ? num_lo : num_hi;

      stage_in[0].valid = lvl_in.valid;
      stage_in[0].alpha = lvl_in.alpha;
      stage_in[0].upper = ~lower_seg;
      stage_in[0].den   = lower_seg ? {n_sat, 1'b0} : {d_w, 1'b0};
      stage_in[0].rem   = {1'b0, num_sel[NUM_W-1:QW]};
      stage_in[0].nlow  = num_sel[QW-1:0];
      stage_in[0].quot  = '0;
   end

   // restoring divide, DIV_BITS quotient bits per stage
   for (genvar st = 0; st < NSTG; st++) begin : g_div
      div_type          cur;
      logic [DEN_W:0]   sh;

      always_comb begin
         cur = stage_ff[st];
         sh  = '0;
         for (int b = 0; b < tmpm_pkg::DIV_BITS; b++) begin
            sh       = {cur.rem, cur.nlow[QW-1]};
            cur.nlow = {cur.nlow[QW-2:0], 1'b0};
            if (sh >= {1'b0, cur.den}) begin
               sh       = sh - {1'b0, cur.den};
               cur.quot = {cur.quot[QW-2:0], 1'b1};
            end else begin
               cur.quot = {cur.quot[QW-2:0], 1'b0};
            end
            cur.rem = sh[DEN_W-1:0];
         end
         stage_in[st+1] = cur;
      end
   end

   for (genvar st = 0; st <= NSTG; st++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[st] <= '0;
         end else begin
            stage_ff[st] <= stage_in[st];
         end
      end
   end

   assign rmp_out.valid = stage_ff[NSTG].valid;
   assign rmp_out.alpha = stage_ff[NSTG].alpha;
   assign rmp_out.value = LW'(stage_ff[NSTG].quot)
                        + (stage_ff[NSTG].upper ? LW'(tmpm_pkg::HALF_Q) : LW'(0));

endmodule

`default_nettype wire

FILE: rtl/core/tmpm_cutoff.sv
`default_nettype none

module tmpm_cutoff (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tmpm_pkg::remap_type  rmp_in,
   input  wire tmpm_pkg::cfg_type    cfg,
   output logic                      rsp_strobe,
   output tmpm_pkg::mask_type        rsp_data
);

   localparam int FB = tmpm_pkg::FRAC_BITS;
   localparam int PW = FB + 9;

   logic [PW-1:0] scaled;
   logic [PW-1:0] lo_lim;
   logic [PW-1:0] hi_lim;
   logic          outside;
   logic          fire;
   logic          opaque;
   logic [PW-1:0] prod_in;
   logic [7:0]    aout_in;

   logic          c_valid_ff;
   logic [PW-1:0] prod_ff;
   logic [7:0]    aout_ff;

   logic              rsp_strobe_ff;
   tmpm_pkg::mask_type rsp_data_ff;
   logic [PW-1:0]     rounded;

   always_comb begin
      scaled  = {rmp_in.value, 8'b0} - PW'(rmp_in.value);
      lo_lim  = {1'b0, cfg.cutoff_low, FB'(0)};
      hi_lim  = {1'b0, cfg.cutoff_high, FB'(0)};
      outside = (scaled < lo_lim) || (scaled > hi_lim);
      opaque  = (cfg.cutoff_mode == tmpm_pkg::CUT_OPAQUE);
      fire    = outside && ((cfg.cutoff_mode == tmpm_pkg::CUT_TRANSPARENT) || opaque);

      prod_in = scaled;
      aout_in = 8'hFF;
      if (cfg.alpha_mode) begin
         aout_in = fire ? (opaque ? 8'hFF : 8'h00) : rmp_in.alpha;
      end else if (fire) begin
         // force fully opaque or fully transparent
         prod_in = opaque ? PW'({8'hFF, FB'(0)}) : PW'(0);
      end
   end

   assign rounded = prod_ff + PW'(tmpm_pkg::HALF_Q);

   always_ff @(posedge clock) begin
      prod_ff                <= prod_in;
      aout_ff                <= aout_in;
      rsp_data_ff.mask_value <= rounded[FB+7:FB];
      rsp_data_ff.out_alpha  <= aout_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         c_valid_ff    <= rmp_in.valid;
         rsp_strobe_ff <= c_valid_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/texture_mask_pixel_map.sv
// Throughput: one pixel per cycle while busy is low; the 8-stage remap divider
// is fully pipelined.
// busy is high only in reset and the cycle after it; results cannot be held off.
// Reset (synchronous, active high) clears all pipeline valid bits and restores
// the register defaults; transactions in flight at reset are dropped.
`default_nettype none

module texture_mask_pixel_map (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire tmpm_pkg::pixel_type          req_data,
   output logic                              rsp_strobe,
   output tmpm_pkg::mask_type                rsp_data,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [tmpm_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [tmpm_pkg::DATA_W-1:0]  pwdata,
   output logic      [tmpm_pkg::DATA_W-1:0]  prdata,
   output logic                              pready
);

   tmpm_pkg::cfg_type   cfg;
   tmpm_pkg::level_type lvl;
   tmpm_pkg::remap_type rmp;
   logic                busy_ff;
   logic                accept;

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   tmpm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tmpm_level u_level (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .pixel    (req_data),
      .cfg      (cfg),
      .lvl_out  (lvl)
   );

   tmpm_remap u_remap (
      .clock   (clock),
      .reset   (reset),
      .lvl_in  (lvl),
      .cfg     (cfg),
      .rmp_out (rmp)
   );

   tmpm_cutoff u_cutoff (
      .clock      (clock),
      .reset      (reset),
      .rmp_in     (rmp),
      .cfg        (cfg),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/core/tmpm_checker.sv
`default_nettype none

module tmpm_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         rsp_strobe,
   input wire tmpm_pkg::mask_type           rsp_data,
   input wire logic                         psel,
   input wire logic                         penable,
   input wire logic                         pwrite,
   input wire logic [tmpm_pkg::ADDR_W-1:0]  paddr,
   input wire logic [tmpm_pkg::DATA_W-1:0]  pwdata,
   input wire logic [tmpm_pkg::DATA_W-1:0]  prdata
);

   localparam int LAT = tmpm_pkg::PIPE_LATENCY;

   logic [LAT-1:0] acc_pipe_ff;
   logic           amode_ff;
   logic           cfg_wr;

   assign cfg_wr = psel & penable & pwrite;

   // track accepted transactions and the alpha mode bit seen on the port
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_pipe_ff <= '0;
         amode_ff    <= 1'b0;
      end else begin
         acc_pipe_ff <= {acc_pipe_ff[LAT-2:0], start & ~busy};
         if (cfg_wr && (paddr[4:2] == tmpm_pkg::REG_ALPHA_MODE)) begin
            amode_ff <= pwdata[0];
         end
      end
   end

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == acc_pipe_ff[LAT-1])
      else $error("result strobe does not match an accepted transaction");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (busy && !rsp_strobe))
      else $error("block not quiet after reset");

   a_alpha_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !amode_ff) |-> (rsp_data.out_alpha == 8'hFF))
      else $error("out_alpha not opaque with alpha mode off");

   a_amode_read: assert property (@(posedge clock) disable iff (reset)
      (psel && !pwrite && (paddr[4:2] == tmpm_pkg::REG_ALPHA_MODE))
         |-> (prdata[0] == amode_ff))
      else $error("alpha mode readback mismatch");

endmodule

bind texture_mask_pixel_map tmpm_checker u_tmpm_checker (.*);

`default_nettype wire

FILE: test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tmpm_pkg::*;

   localparam longint ONE_L  = longint'(ONE_Q);
   localparam longint HALF_L = longint'(HALF_Q);
   localparam longint Q12_L  = longint'(Q12_ONE);

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   pixel_type           req_data;
   logic                rsp_strobe;
   mask_type            rsp_data;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   cfg_type             live_cfg;
   mask_type            expected_masks[$];
   int                  mismatch_count;
   int                  idle_pct;

   texture_mask_pixel_map DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("testbench NOT OK");
      $finish;
   end

   // floor division for a positive divisor
   function automatic longint floor_div(input longint n, input longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic mask_type predict_mask(input pixel_type p, input cfg_type c);
      longint gray, num, m, bq, v, n, d, lo, hi;
      logic   outside;
      logic [7:0] alpha_out;
      mask_type r;
      gray = (longint'(p.red) * 11 + longint'(p.green) * 16 + longint'(p.blue) * 5) / 32;
      num  = gray * longint'(p.alpha) + 255 * (255 - longint'(p.alpha));
      m    = (num * ONE_L + 32512) / 65025;
      bq   = floor_div(longint'($signed(c.brightness)) * ONE_L + 2048, Q12_L);
      m    = m - bq;
      m    = floor_div((m - HALF_L) * longint'(c.contrast) + 2048, Q12_L) + HALF_L;
      if (m > ONE_L) m = ONE_L;
      else if (m < 0) m = 0;
      if (c.invert_enable) m = ONE_L - m;

      n = longint'(c.neutral_point);
      if (n > Q12_L) n = Q12_L;
      if (n == Q12_L || (n != 0 && m * Q12_L <= n * ONE_L)) begin
         v = (m * Q12_L + n) / (2 * n);
      end else begin
         d = Q12_L - n;
         v = HALF_L + (m * Q12_L - n * ONE_L + d) / (2 * d);
      end
      if (v > ONE_L) v = ONE_L;
      if (v < 0) v = 0;

      lo = longint'(c.cutoff_low);
      hi = longint'(c.cutoff_high);
      outside   = (v * 255 < lo * ONE_L) || (v * 255 > hi * ONE_L);
      alpha_out = p.alpha;
      if (outside && (c.cutoff_mode == CUT_TRANSPARENT || c.cutoff_mode == CUT_OPAQUE)) begin
         alpha_out = (c.cutoff_mode == CUT_TRANSPARENT) ? 8'd0 : 8'd255;
         if (!c.alpha_mode) v = (c.cutoff_mode == CUT_TRANSPARENT) ? 0 : ONE_L;
      end
      if (!c.alpha_mode) alpha_out = 8'd255;
      r.mask_value = 8'((v * 255 + HALF_L) >>> FRAC_BITS);
      r.out_alpha  = alpha_out;
      return r;
   endfunction

   // compare each result with the oldest expected mask
   always @(posedge clock) begin
      mask_type want;
      if (!reset && rsp_strobe) begin
         if (expected_masks.size() == 0) begin
            $error("unexpected result: mask_value %0d out_alpha %0d",
                   rsp_data.mask_value, rsp_data.out_alpha);
            mismatch_count++;
         end else begin
            want = expected_masks.pop_front();
            if (rsp_data.mask_value !== want.mask_value) begin
               $error("mask_value: expected %0d, actual %0d",
                      want.mask_value, rsp_data.mask_value);
               mismatch_count++;
            end
            if (rsp_data.out_alpha !== want.out_alpha) begin
               $error("out_alpha: expected %0d, actual %0d",
                      want.out_alpha, rsp_data.out_alpha);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_pixel(input pixel_type p);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start    <= 1'b1;
      req_data <= p;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      expected_masks.push_back(predict_mask(p, live_cfg));
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      while (expected_masks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves psel high; the caller closes the transfer
   task automatic write_csr(input logic [2:0] idx, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (pready) break;
      end
   endtask

   task automatic set_config(input cfg_type c);
      drain_pipeline();
      write_csr(REG_BRIGHTNESS,  DATA_W'(c.brightness));
      write_csr(REG_CONTRAST,    DATA_W'(c.contrast));
      write_csr(REG_NEUTRAL,     DATA_W'(c.neutral_point));
      write_csr(REG_INVERT,      DATA_W'(c.invert_enable));
      write_csr(REG_CUTOFF_LOW,  DATA_W'(c.cutoff_low));
      write_csr(REG_CUTOFF_HIGH, DATA_W'(c.cutoff_high));
      write_csr(REG_CUTOFF_MODE, DATA_W'(c.cutoff_mode));
      write_csr(REG_ALPHA_MODE,  DATA_W'(c.alpha_mode));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      live_cfg = c;
      @(posedge clock);
   endtask

   function automatic pixel_type make_pixel(input int r, input int g, input int b,
                                            input int a);
      pixel_type p;
      p.red   = 8'(r);
      p.green = 8'(g);
      p.blue  = 8'(b);
      p.alpha = 8'(a);
      return p;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      p = pixel_type'($urandom);
      case ($urandom_range(9))
         0: p.alpha = 8'd255;
         1: p.alpha = 8'd0;
         2: begin
            p.red   = {8{p.red[0]}};
            p.green = {8{p.green[0]}};
            p.blue  = {8{p.blue[0]}};
         end
         3: p.alpha = {8{p.alpha[0]}};
         default: ;
      endcase
      return p;
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      case ($urandom_range(9))
         0: c.brightness = -14'sd4096;
         1: c.brightness = 14'sd4096;
         2: c.brightness = 14'($urandom);
         3: c.brightness = 14'sd0;
         default: c.brightness = 14'($signed($urandom_range(2048)) - 1024);
      endcase
      case ($urandom_range(9))
         0: c.contrast = 16'd0;
         1: c.contrast = 16'hFFFF;
         2: c.contrast = 16'($urandom);
         3: c.contrast = 16'd4096;
         default: c.contrast = 16'($urandom_range(8192, 2048));
      endcase
      case ($urandom_range(9))
         0: c.neutral_point = 13'd0;
         1: c.neutral_point = 13'd4096;
         2: c.neutral_point = 13'($urandom);
         3: c.neutral_point = 13'd2048;
         default: c.neutral_point = 13'($urandom_range(4096));
      endcase
      c.invert_enable = 1'($urandom);
      c.cutoff_low    = ($urandom_range(3) == 0) ? 8'd0   : 8'($urandom_range(128));
      c.cutoff_high   = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(255, 100));
      if ($urandom_range(5) == 0) c.cutoff_low = 8'($urandom);
      c.cutoff_mode   = 2'($urandom);
      c.alpha_mode    = 1'($urandom);
      return c;
   endfunction

   task automatic test_reset_defaults();
      send_pixel(make_pixel(0, 0, 0, 255));
      send_pixel(make_pixel(255, 255, 255, 255));
      send_pixel(make_pixel(0, 0, 0, 0));
      send_pixel(make_pixel(128, 128, 128, 128));
      send_pixel(make_pixel(255, 0, 0, 255));
      send_pixel(make_pixel(0, 255, 0, 1));
      send_pixel(make_pixel(0, 0, 255, 254));
   endtask

   task automatic test_special_cases();
      cfg_type c;
      // neutral point at one, inverted
      c = CFG_RESET;
      c.neutral_point = 13'd4096;
      c.invert_enable = 1'b1;
      set_config(c);
      send_pixel(make_pixel(0, 0, 0, 255));
      send_pixel(make_pixel(200, 100, 50, 255));
      // neutral point at zero
      c = CFG_RESET;
      c.neutral_point = 13'd0;
      set_config(c);
      send_pixel(make_pixel(0, 0, 0, 255));
      send_pixel(make_pixel(90, 90, 90, 200));
      // neutral point above one saturates
      c.neutral_point = 13'h1FFF;
      set_config(c);
      send_pixel(make_pixel(60, 120, 180, 255));
      // unused cutoff mode passes everything
      c = CFG_RESET;
      c.cutoff_low  = 8'd100;
      c.cutoff_high = 8'd120;
      c.cutoff_mode = 2'd3;
      c.alpha_mode  = 1'b1;
      set_config(c);
      send_pixel(make_pixel(0, 0, 0, 255));
      send_pixel(make_pixel(255, 255, 255, 77));
      // inverted cutoff range: every value is outside
      c = CFG_RESET;
      c.cutoff_low  = 8'd200;
      c.cutoff_high = 8'd50;
      c.cutoff_mode = CUT_TRANSPARENT;
      set_config(c);
      send_pixel(make_pixel(128, 128, 128, 255));
      send_pixel(make_pixel(255, 255, 255, 0));
      c.cutoff_mode = CUT_OPAQUE;
      c.alpha_mode  = 1'b1;
      set_config(c);
      send_pixel(make_pixel(128, 128, 128, 99));
      send_pixel(make_pixel(10, 20, 30, 255));
      // brightness and contrast at the limits of their fields
      c = CFG_RESET;
      c.brightness = -14'sd8192;
      c.contrast   = 16'hFFFF;
      set_config(c);
      send_pixel(make_pixel(0, 0, 0, 255));
      send_pixel(make_pixel(255, 255, 255, 255));
      c.brightness = 14'sd8191;
      c.contrast   = 16'd0;
      set_config(c);
      send_pixel(make_pixel(0, 0, 0, 255));
      send_pixel(make_pixel(255, 255, 255, 255));
   endtask

   task automatic test_random_stream();
      int pcts[3] = '{38, 66, 0};
      foreach (pcts[ph]) begin
         idle_pct = pcts[ph];
         repeat (4) begin
            set_config(random_config());
            repeat (50) send_pixel(random_pixel());
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_data       <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      live_cfg        = CFG_RESET;
      mismatch_count  = 0;
      idle_pct        = 38;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_special_cases();
      test_random_stream();

      drain_pipeline();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/tmpm_pkg.sv
rtl/core/tmpm_csr.sv
rtl/core/tmpm_level.sv
rtl/core/tmpm_remap.sv
rtl/core/tmpm_cutoff.sv
rtl/core/texture_mask_pixel_map.sv
rtl/core/tmpm_checker.sv
test/testbench.sv
